// ----- sv/swipe_velocity_tracker_top_defines.svh -----
// ----------------------------------------------------------------------------
// Swipe velocity tracker assertion macros
// Assertion helpers for the tracker; they expand to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef SWIPE_VELOCITY_TRACKER_TOP_DEFINES_SVH
`define SWIPE_VELOCITY_TRACKER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SVT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("svt assertion failed");
`define SVT_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("svt assertion failed");
`else
`define SVT_ASSERT(lbl, prop)
`define SVT_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- sv/svt_pkg.sv -----
// ----------------------------------------------------------------------------
// Swipe velocity tracker package
// Shared types and codes of the tracker.
// ----------------------------------------------------------------------------
package svt_pkg;

	localparam logic CMD_STORE = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	localparam logic REG_WINDOW_LENGTH = 1'b0;
	localparam logic REG_MIN_GAP       = 1'b1;

	localparam logic [4:0]  WINDOW_LENGTH_RESET = 5'd16;
	localparam logic [19:0] MIN_GAP_RESET       = 20'd1000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_RD0,
		ST_LOADA,
		ST_PAIR,
		ST_MUL,
		ST_DIVGO,
		ST_DIVW,
		ST_NEXTP,
		ST_MEANGO,
		ST_MEANW,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic start;
	} div_ctl_t;

endpackage

// ----- sv/svt_ring.sv -----
// ----------------------------------------------------------------------------
// Swipe velocity tracker sample ring
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module svt_ring #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [63:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [63:0]   rdata
);

	logic [63:0] mem [DEPTH];
	logic [63:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/svt_div.sv -----
// ----------------------------------------------------------------------------
// Swipe velocity tracker divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module svt_div #(
	parameter int QW = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  svt_pkg::div_ctl_t ctl_in,
	input  logic [QW-1:0]    dividend,
	input  logic [31:0]      divisor,
	output logic             done,
	output logic [QW-1:0]    quotient
);

	localparam int NW = $clog2(QW + 1);

	logic [31:0]   rem_q;
	logic [QW-1:0] quo_q;
	logic [31:0]   div_q;
	logic [NW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [32:0]   trial;
	logic          ge;

	assign trial = {rem_q, quo_q[QW-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl_in.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= NW'(QW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == NW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? 32'(trial - {1'b0, div_q}) : trial[31:0];
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- sv/swipe_velocity_tracker_top.sv -----
// ----------------------------------------------------------------------------
// Swipe velocity tracker
// Windowed touch sample store with mean pair velocity and swipe distance.
// ----------------------------------------------------------------------------
//  channel | signals                         | direction
//  in      | in_valid/in_ready, cmd..stamp   | sample or clear command
//  out     | out_valid/out_ready, vel..count | one result beat per input beat
//  cfg     | cfg_valid/cfg_ready, index/data | register writes, always ready
//
// One item at a time. A clear goes from PREP straight to FIN. A store runs
// each timed pair through the two bit-serial dividers, QW = 16 + log2(TPS) +
// log2(WINDOW_DEPTH) (40 at defaults) bits wide, then the mean if any pair
// was timed; skipped pairs bypass the dividers. A waiting result does not block
// the next input beat; the block stalls only at the end of the following item.
// The ring needs no clearing after reset.
`include "swipe_velocity_tracker_top_defines.svh"
module swipe_velocity_tracker_top #(
	parameter int WINDOW_DEPTH     = 16,
	parameter int TICKS_PER_SECOND = 1000000
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic [31:0]        time_stamp,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	output logic signed [16:0] dist_x,
	output logic signed [16:0] dist_y,
	output logic signed [15:0] last_x,
	output logic signed [15:0] last_y,
	output logic [31:0]        last_time,
	output logic               is_empty,
	output logic [4:0]         sample_count,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [19:0]        cfg_data
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam int TW = $clog2(TICKS_PER_SECOND + 1);
	localparam int PW = 16 + TW;
	localparam int QW = PW + AW;
	localparam int SW = QW + 1;
	localparam logic [TW-1:0] TPS_C = TW'(TICKS_PER_SECOND);

	svt_pkg::state_t state_q, state_n;

	logic [4:0]  wlen_q;
	logic [19:0] min_gap_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] cnt_q;
	logic signed [15:0] org_x_q, org_y_q;
	logic        cmd_q;
	logic signed [15:0] in_x_q, in_y_q;
	logic [31:0] in_t_q;
	logic [CW-1:0] k_q, n_q;
	logic [63:0] prev_q;
	logic signed [SW-1:0] sum_x_q, sum_y_q;
	logic signed [31:0] res_x_q, res_y_q;
	logic signed [16:0] px_s1, py_s1;
	logic [PW-1:0] prod_x_s2, prod_y_s2;
	logic neg_x_s2, neg_y_s2;
	logic out_valid_q;
	logic signed [31:0] vel_x_q, vel_y_q;
	logic signed [16:0] dist_x_q, dist_y_q;
	logic signed [15:0] last_x_q, last_y_q;
	logic [31:0] last_t_q;
	logic        empty_q;
	logic [CW-1:0] count_q;

	function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] k);
		logic [CW:0] s;
		s = (CW + 1)'(base) + (CW + 1)'(k);
		if (s >= (CW + 1)'(WINDOW_DEPTH)) begin
			s = s - (CW + 1)'(WINDOW_DEPTH);
		end
		return AW'(s);
	endfunction

	// Window limit with zero read as one and large values read as the depth.
	logic [CW-1:0] limit;
	logic          drop;
	logic [AW-1:0] head_n;
	logic [CW-1:0] cnt_adj;
	always_comb begin
		if (wlen_q == 5'd0) begin
			limit = CW'(1);
		end else if (int'(wlen_q) > WINDOW_DEPTH) begin
			limit = CW'(WINDOW_DEPTH);
		end else begin
			limit = CW'(wlen_q);
		end
		drop    = (cnt_q >= limit) && (cnt_q != '0);
		head_n  = drop ? slot(head_q, CW'(1)) : head_q;
		cnt_adj = drop ? cnt_q - 1'b1 : cnt_q;
	end

	logic          ring_we;
	logic [AW-1:0] ring_waddr, ring_raddr;
	logic [63:0]   ring_rdata;
	assign ring_we    = (state_q == svt_pkg::ST_PREP) && (cmd_q == svt_pkg::CMD_STORE);
	assign ring_waddr = slot(head_n, cnt_adj);
	assign ring_raddr = slot(head_q, (state_q == svt_pkg::ST_NEXTP) ? k_q + 1'b1 : k_q);

	svt_ring #(.DEPTH(WINDOW_DEPTH), .AW(AW)) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata ({in_t_q, in_y_q, in_x_q}),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	// Pair terms: prev_q is the older sample, the read data the newer one.
	logic [32:0] gap;
	logic        pair_ok;
	assign gap     = {1'b0, ring_rdata[63:32]} - {1'b0, prev_q[63:32]};
	assign pair_ok = !gap[32] && (gap[31:0] > 32'(min_gap_q));

	svt_pkg::div_ctl_t ctl_x, ctl_y;
	logic [QW-1:0] dvd_x, dvd_y, quo_x, quo_y;
	logic [31:0]   dvs;
	logic [31:0]   gap_q;
	logic          done_x, done_y;
	logic          mean_phase;

	assign mean_phase  = (state_q == svt_pkg::ST_MEANGO);
	assign ctl_x.start = (state_q == svt_pkg::ST_DIVGO) || mean_phase;
	assign ctl_y.start = ctl_x.start;
	assign dvd_x = mean_phase ? QW'(sum_x_q[SW-1] ? -sum_x_q : sum_x_q) : QW'(prod_x_s2);
	assign dvd_y = mean_phase ? QW'(sum_y_q[SW-1] ? -sum_y_q : sum_y_q) : QW'(prod_y_s2);
	assign dvs   = mean_phase ? 32'(n_q) : gap_q;

	svt_div #(.QW(QW)) u_div_x (
		.clk(clk), .arst_n(arst_n), .ctl_in(ctl_x), .dividend(dvd_x),
		.divisor(dvs), .done(done_x), .quotient(quo_x)
	);
	svt_div #(.QW(QW)) u_div_y (
		.clk(clk), .arst_n(arst_n), .ctl_in(ctl_y), .dividend(dvd_y),
		.divisor(dvs), .done(done_y), .quotient(quo_y)
	);

	function automatic logic signed [SW-1:0] apply_sign(input logic [QW-1:0] q, input logic neg);
		logic signed [SW-1:0] v;
		v = $signed({1'b0, q});
		return neg ? -v : v;
	endfunction

	function automatic logic signed [31:0] sat_mean(input logic [QW-1:0] q, input logic neg);
		logic signed [31:0] r;
		if (!neg) begin
			r = (q > QW'(32'h7fff_ffff)) ? 32'sh7fff_ffff : $signed(q[31:0]);
		end else begin
			r = (q > QW'(33'h0_8000_0000)) ? 32'sh8000_0000 : -$signed(q[31:0]);
		end
		return r;
	endfunction

	logic out_load;
	logic both_done;
	assign both_done = done_x && done_y;
	assign out_load  = (state_q == svt_pkg::ST_FIN) && (!out_valid_q || out_ready);
	assign in_ready  = (state_q == svt_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			svt_pkg::ST_IDLE:   if (in_valid) state_n = svt_pkg::ST_PREP;
			svt_pkg::ST_PREP: begin
				if (cmd_q == svt_pkg::CMD_CLEAR || cnt_adj == '0) begin
					state_n = svt_pkg::ST_FIN;
				end else begin
					state_n = svt_pkg::ST_RD0;
				end
			end
			svt_pkg::ST_RD0:    state_n = svt_pkg::ST_LOADA;
			svt_pkg::ST_LOADA:  state_n = svt_pkg::ST_PAIR;
			svt_pkg::ST_PAIR:   state_n = pair_ok ? svt_pkg::ST_MUL : svt_pkg::ST_NEXTP;
			svt_pkg::ST_MUL:    state_n = svt_pkg::ST_DIVGO;
			svt_pkg::ST_DIVGO:  state_n = svt_pkg::ST_DIVW;
			svt_pkg::ST_DIVW:   if (both_done) state_n = svt_pkg::ST_NEXTP;
			svt_pkg::ST_NEXTP: begin
				if ((CW + 1)'(k_q) + 1'b1 < (CW + 1)'(cnt_q)) begin
					state_n = svt_pkg::ST_PAIR;
				end else if (n_q == '0) begin
					state_n = svt_pkg::ST_FIN;
				end else begin
					state_n = svt_pkg::ST_MEANGO;
				end
			end
			svt_pkg::ST_MEANGO: state_n = svt_pkg::ST_MEANW;
			svt_pkg::ST_MEANW:  if (both_done) state_n = svt_pkg::ST_FIN;
			svt_pkg::ST_FIN:    if (out_load) state_n = svt_pkg::ST_IDLE;
			default:            state_n = svt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= svt_pkg::ST_IDLE;
			wlen_q      <= svt_pkg::WINDOW_LENGTH_RESET;
			min_gap_q   <= svt_pkg::MIN_GAP_RESET;
			head_q      <= '0;
			cnt_q       <= '0;
			org_x_q     <= '0;
			org_y_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					svt_pkg::REG_WINDOW_LENGTH: wlen_q    <= cfg_data[4:0];
					svt_pkg::REG_MIN_GAP:       min_gap_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == svt_pkg::ST_PREP) begin
				if (cmd_q == svt_pkg::CMD_CLEAR) begin
					head_q  <= '0;
					cnt_q   <= '0;
					org_x_q <= '0;
					org_y_q <= '0;
				end else begin
					head_q <= head_n;
					cnt_q  <= cnt_adj + 1'b1;
					if (cnt_adj == '0) begin
						org_x_q <= in_x_q;
						org_y_q <= in_y_q;
					end
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			svt_pkg::ST_IDLE: begin
				cmd_q  <= cmd;
				in_x_q <= pos_x;
				in_y_q <= pos_y;
				in_t_q <= time_stamp;
			end
			svt_pkg::ST_PREP: begin
				k_q     <= '0;
				n_q     <= '0;
				sum_x_q <= '0;
				sum_y_q <= '0;
				res_x_q <= '0;
				res_y_q <= '0;
			end
			svt_pkg::ST_RD0:   k_q <= CW'(1);
			svt_pkg::ST_LOADA: prev_q <= ring_rdata;
			svt_pkg::ST_PAIR: begin
				prev_q <= ring_rdata;
				px_s1  <= $signed({ring_rdata[15], ring_rdata[15:0]})
					- $signed({prev_q[15], prev_q[15:0]});
				py_s1  <= $signed({ring_rdata[31], ring_rdata[31:16]})
					- $signed({prev_q[31], prev_q[31:16]});
				gap_q  <= gap[31:0];
			end
			svt_pkg::ST_MUL: begin
				prod_x_s2 <= 16'(px_s1[16] ? -px_s1 : px_s1) * TPS_C;
				prod_y_s2 <= 16'(py_s1[16] ? -py_s1 : py_s1) * TPS_C;
				neg_x_s2  <= px_s1[16];
				neg_y_s2  <= py_s1[16];
			end
			svt_pkg::ST_DIVW: begin
				if (both_done) begin
					sum_x_q <= sum_x_q + apply_sign(quo_x, neg_x_s2);
					sum_y_q <= sum_y_q + apply_sign(quo_y, neg_y_s2);
					n_q     <= n_q + 1'b1;
				end
			end
			svt_pkg::ST_NEXTP: k_q <= k_q + 1'b1;
			svt_pkg::ST_MEANW: begin
				if (both_done) begin
					res_x_q <= sat_mean(quo_x, sum_x_q[SW-1]);
					res_y_q <= sat_mean(quo_y, sum_y_q[SW-1]);
				end
			end
			default: ;
		endcase
		if (out_load) begin
			vel_x_q <= res_x_q;
			vel_y_q <= res_y_q;
			count_q <= cnt_q;
			empty_q <= (cnt_q == '0);
			if (cnt_q == '0) begin
				dist_x_q <= '0;
				dist_y_q <= '0;
				last_x_q <= '0;
				last_y_q <= '0;
				last_t_q <= '0;
			end else begin
				dist_x_q <= 17'(in_x_q) - 17'(org_x_q);
				dist_y_q <= 17'(in_y_q) - 17'(org_y_q);
				last_x_q <= in_x_q;
				last_y_q <= in_y_q;
				last_t_q <= in_t_q;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign vel_x        = vel_x_q;
	assign vel_y        = vel_y_q;
	assign dist_x       = dist_x_q;
	assign dist_y       = dist_y_q;
	assign last_x       = last_x_q;
	assign last_y       = last_y_q;
	assign last_time    = last_t_q;
	assign is_empty     = empty_q;
	assign sample_count = 5'(count_q);

	`SVT_ASSERT(a_count_bound, cnt_q <= CW'(WINDOW_DEPTH))
	`SVT_ASSERT(a_one_at_a_time, (in_valid && in_ready) |=> !in_ready)
	`SVT_ASSERT(a_result_from_fin, $rose(out_valid) |-> $past(state_q == svt_pkg::ST_FIN))
	`SVT_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !out_valid)

endmodule

// ----- tb/sv/tb_swipe_velocity_tracker_top.sv -----
// ----------------------------------------------------------------------------
// Swipe velocity tracker testbench
// Drives store and clear beats under random stalls, predicts every result
// with a behavioral copy of the window and velocity math, and compares.
// ----------------------------------------------------------------------------
module tb_swipe_velocity_tracker_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;
	localparam longint TPS = 1000000;

	typedef struct {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [16:0] dx;
		logic signed [16:0] dy;
		logic signed [15:0] lx;
		logic signed [15:0] ly;
		logic [31:0]        lt;
		logic               emp;
		logic [4:0]         cnt;
	} swipe_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid = 1'b0, in_ready;
	logic cmd = svt_pkg::CMD_STORE;
	logic signed [15:0] pos_x = '0, pos_y = '0;
	logic [31:0] time_stamp = '0;
	logic out_valid, out_ready = 1'b0;
	logic signed [31:0] vel_x, vel_y;
	logic signed [16:0] dist_x, dist_y;
	logic signed [15:0] last_x, last_y;
	logic [31:0] last_time;
	logic is_empty;
	logic [4:0] sample_count;
	logic cfg_valid = 1'b0, cfg_ready;
	logic cfg_index = svt_pkg::REG_WINDOW_LENGTH;
	logic [19:0] cfg_data = '0;

	swipe_result_t expected_results[$];
	int errors = 0;
	bit quiet = 1'b0;
	logic [31:0] now_tick = '0;

	// Predictor state.
	logic signed [15:0] ring_x[DEPTH];
	logic signed [15:0] ring_y[DEPTH];
	logic [31:0] ring_t[DEPTH];
	int head = 0, count = 0;
	logic signed [15:0] org_x = '0, org_y = '0;
	logic [4:0] win_len = svt_pkg::WINDOW_LENGTH_RESET;
	logic [19:0] gap_min = svt_pkg::MIN_GAP_RESET;

	swipe_velocity_tracker_top i_dut (.*);

	always #4 clk = ~clk;

	function automatic longint saturate32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic swipe_result_t track_sample(logic c, logic signed [15:0] x,
			logic signed [15:0] y, logic [31:0] t);
		swipe_result_t r;
		int lim, s, a, b, n;
		longint sx, sy, gap;
		lim = win_len;
		if (lim < 1)
			lim = 1;
		if (lim > DEPTH)
			lim = DEPTH;
		r = '{default: '0};
		if (c == svt_pkg::CMD_CLEAR) begin
			head = 0;
			count = 0;
			org_x = '0;
			org_y = '0;
		end else begin
			if (count >= lim && count > 0) begin
				head = (head + 1) % DEPTH;
				count--;
			end
			s = (head + count) % DEPTH;
			ring_x[s] = x;
			ring_y[s] = y;
			ring_t[s] = t;
			count++;
			if (count == 1) begin
				org_x = x;
				org_y = y;
			end
		end
		if (count > 0) begin
			s = (head + count - 1) % DEPTH;
			r.lx = ring_x[s];
			r.ly = ring_y[s];
			r.lt = ring_t[s];
			r.dx = 17'(longint'(ring_x[s]) - longint'(org_x));
			r.dy = 17'(longint'(ring_y[s]) - longint'(org_y));
		end
		sx = 0;
		sy = 0;
		n = 0;
		for (int k = 0; k + 1 < count; k++) begin
			a = (head + k) % DEPTH;
			b = (head + k + 1) % DEPTH;
			gap = longint'({1'b0, ring_t[b]}) - longint'({1'b0, ring_t[a]});
			if (gap > longint'({1'b0, gap_min})) begin
				sx += (longint'(ring_x[b]) - longint'(ring_x[a])) * TPS / gap;
				sy += (longint'(ring_y[b]) - longint'(ring_y[a])) * TPS / gap;
				n++;
			end
		end
		if (n > 0) begin
			r.vx = 32'(saturate32(sx / n));
			r.vy = 32'(saturate32(sy / n));
		end
		r.emp = (count == 0);
		r.cnt = 5'(count);
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Valid stays high after a beat so that a following beat can go out back to
	// back; it drops only while idling or while waiting for results.
	task automatic send_item(logic c, logic signed [15:0] x, logic signed [15:0] y,
			logic [31:0] t);
		if (!quiet && $urandom_range(3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(18, 1)) @(posedge clk);
		end
		cmd <= c;
		pos_x <= x;
		pos_y <= y;
		time_stamp <= t;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_results.insert(expected_results.size(), track_sample(c, x, y, t));
	endtask

	task automatic store(logic signed [15:0] x, logic signed [15:0] y, logic [31:0] t);
		send_item(svt_pkg::CMD_STORE, x, y, t);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [19:0] val);
		wait_drained();
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == svt_pkg::REG_WINDOW_LENGTH)
			win_len = val[4:0];
		else
			gap_min = val;
	endtask

	// Result checker: one beat per expected result, in order.
	always @(posedge clk) begin
		swipe_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected beat", 1, 0);
			end else begin
				e = expected_results[0];
				expected_results.delete(0);
				if (vel_x !== e.vx) report_mismatch("vel_x", vel_x, e.vx);
				if (vel_y !== e.vy) report_mismatch("vel_y", vel_y, e.vy);
				if (dist_x !== e.dx) report_mismatch("dist_x", dist_x, e.dx);
				if (dist_y !== e.dy) report_mismatch("dist_y", dist_y, e.dy);
				if (last_x !== e.lx) report_mismatch("last_x", last_x, e.lx);
				if (last_y !== e.ly) report_mismatch("last_y", last_y, e.ly);
				if (last_time !== e.lt) report_mismatch("last_time", last_time, e.lt);
				if (is_empty !== e.emp) report_mismatch("is_empty", is_empty, e.emp);
				if (sample_count !== e.cnt)
					report_mismatch("sample_count", sample_count, e.cnt);
			end
		end
	end

	// Receiver stalls in bursts.
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(3) == 0) begin
				n = $urandom_range(18, 1);
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	task automatic test_directed();
		store(16'sh7fff, -16'sh8000, 32'd0);
		store(-16'sh8000, 16'sh7fff, 32'd1001);
		store(16'sh7fff, -16'sh8000, 32'd1002);
		store(16'sh0000, 16'sh0000, 32'd500);
		store(16'sh7fff, 16'sh7fff, 32'hffff_fff0);
		store(-16'sh8000, -16'sh8000, 32'hffff_ffff);
		send_item(svt_pkg::CMD_CLEAR, 16'sh1234, -16'sh1234, 32'hdead_beef);
		send_item(svt_pkg::CMD_CLEAR, '0, '0, '0);
		store(16'sh0100, -16'sh0100, 32'd2000);
		store(16'sh0200, -16'sh0300, 32'd4000);
	endtask

	task automatic test_saturation();
		write_reg(svt_pkg::REG_MIN_GAP, 20'd0);
		send_item(svt_pkg::CMD_CLEAR, '0, '0, '0);
		for (int i = 0; i < 8; i++)
			store(i[0] ? 16'sh7fff : -16'sh8000, i[0] ? -16'sh8000 : 16'sh7fff,
				32'(i + 10));
		write_reg(svt_pkg::REG_MIN_GAP, 20'hfffff);
		store(16'sh0, 16'sh0, 32'd3000000);
	endtask

	task automatic test_window_length();
		logic [4:0] lens[6] = '{5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd16};
		for (int l = 0; l < 6; l++) begin
			write_reg(svt_pkg::REG_WINDOW_LENGTH, {15'd0, lens[l]});
			for (int i = 0; i < 5; i++) begin
				now_tick += $urandom_range(3000);
				store(16'($urandom), 16'($urandom), now_tick);
			end
		end
		// Shrinking below the count drops one sample per store.
		write_reg(svt_pkg::REG_WINDOW_LENGTH, 20'd3);
		store(16'sh10, 16'sh20, now_tick + 5000);
	endtask

	task automatic test_random();
		int r;
		for (int phase = 0; phase < 6; phase++) begin
			write_reg(svt_pkg::REG_WINDOW_LENGTH, 20'($urandom_range(16, 1)));
			write_reg(svt_pkg::REG_MIN_GAP,
				phase == 5 ? 20'd1000000 : 20'($urandom_range(2000)));
			if (phase == 5)
				quiet = 1'b1;
			for (int i = 0; i < 90; i++) begin
				r = $urandom_range(99);
				if (r < 4) begin
					send_item(svt_pkg::CMD_CLEAR, 16'($urandom), 16'($urandom), $urandom);
				end else if (r < 10) begin
					store(16'($urandom), 16'($urandom), $urandom);
				end else begin
					now_tick += (r < 20) ? $urandom_range(1500) :
						(r < 25 ? 32'($urandom_range(2000000)) : $urandom_range(40000));
					store(16'($urandom), 16'($urandom), now_tick);
				end
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_saturation();
		test_window_length();
		test_random();
		wait_drained();
		if (errors == 0)
			$display("swipe_velocity_tracker_top regression: pass");
		else
			$display("swipe_velocity_tracker_top regression: fail");
		$finish;
	end

	initial begin
		#40ms;
		$display("swipe_velocity_tracker_top regression: fail");
		$finish;
	end

endmodule
